// ----- hw/rtl/chip8_pkg.sv -----
// Shared types, constants and tables for the CHIP-8 instruction core.
// No dependencies; used by every module under hw/rtl except chip8_ram.
package chip8_pkg;

   localparam int MEM_BYTES  = 4096;
   localparam int MEM_AW     = 12;
   localparam int SCR_W      = 64;
   localparam int SCR_H      = 32;
   localparam int SCR_AW     = 5;
   localparam int STK_DEPTH  = 16;
   localparam int FONT_BYTES = 80;

   localparam logic [11:0] PC_BOOT = 12'h200;

   // item kinds
   localparam logic [1:0] OPN_LOAD = 2'd0;
   localparam logic [1:0] OPN_BOOT = 2'd1;
   localparam logic [1:0] OPN_EXEC = 2'd2;
   localparam logic [1:0] OPN_READ = 2'd3;

   // configuration register indexes
   localparam logic CSR_SHIFT_VX = 1'b0;
   localparam logic CSR_DBL_ADV  = 1'b1;

   // instruction groups (top nibble)
   localparam logic [3:0] GRP_SYS  = 4'h0;
   localparam logic [3:0] GRP_JP   = 4'h1;
   localparam logic [3:0] GRP_CALL = 4'h2;
   localparam logic [3:0] GRP_SE   = 4'h3;
   localparam logic [3:0] GRP_SNE  = 4'h4;
   localparam logic [3:0] GRP_SER  = 4'h5;
   localparam logic [3:0] GRP_LD   = 4'h6;
   localparam logic [3:0] GRP_ADD  = 4'h7;
   localparam logic [3:0] GRP_ALU  = 4'h8;
   localparam logic [3:0] GRP_SNER = 4'h9;
   localparam logic [3:0] GRP_LDI  = 4'hA;
   localparam logic [3:0] GRP_JPV0 = 4'hB;
   localparam logic [3:0] GRP_RND  = 4'hC;
   localparam logic [3:0] GRP_DRAW = 4'hD;
   localparam logic [3:0] GRP_KEY  = 4'hE;
   localparam logic [3:0] GRP_MISC = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] NN_SKP    = 8'h9E;
   localparam logic [7:0] NN_SKNP   = 8'hA1;
   localparam logic [7:0] NN_GETDLY = 8'h07;
   localparam logic [7:0] NN_WAITK  = 8'h0A;
   localparam logic [7:0] NN_SETDLY = 8'h15;
   localparam logic [7:0] NN_SETSND = 8'h18;
   localparam logic [7:0] NN_ADDI   = 8'h1E;
   localparam logic [7:0] NN_FONT   = 8'h29;
   localparam logic [7:0] NN_BCD    = 8'h33;
   localparam logic [7:0] NN_STORE  = 8'h55;
   localparam logic [7:0] NN_LOADR  = 8'h65;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // byte to three BCD digits, built at elaboration
   typedef logic [11:0] bcd_rom_type [256];

   function automatic bcd_rom_type gen_bcd_rom();
      bcd_rom_type rom;
      for (int i = 0; i < 256; i++) begin
         rom[i] = {4'(i / 100), 4'((i / 10) % 10), 4'(i % 10)};
      end
      return rom;
   endfunction

   localparam bcd_rom_type BCD_ROM = gen_bcd_rom();

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] load_address;
      logic [7:0]  load_data;
      logic [15:0] keys_down;
      logic [7:0]  random_byte;
      logic [4:0]  row_select;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [15:0] opcode_done;
      logic [15:0] index_value;
      logic [7:0]  flag_value;
      logic        waiting_key;
      logic [63:0] display_row;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLR, CMD_CAPTURE, CMD_LOAD, CMD_BOOT,
      CMD_FETCH0, CMD_FETCH1, CMD_FETCH2, CMD_RDX, CMD_RDY, CMD_EXEC,
      CMD_DMEM, CMD_DSCR, CMD_DWR, CMD_BCD, CMD_STO, CMD_LDR, CMD_LDW,
      CMD_IADV, CMD_ROWRD, CMD_OUT
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic        clr_last;
      logic [15:0] opcode;
      logic        last_row;
      logic        last_reg;
      logic        last_bcd;
      logic        row_ok;
   } sts_type;

endpackage

// ----- hw/rtl/chip8_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module chip8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/chip8_ctrl.sv -----
// Sequencer for the CHIP-8 core: one-hot state machine issuing datapath commands.
// Depends on chip8_pkg.
module chip8_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  chip8_pkg::sts_type sts,
   output chip8_pkg::ctl_type ctl
);

   typedef enum logic [19:0] {
      S_CLEAR  = 20'h00001,
      S_IDLE   = 20'h00002,
      S_LOAD   = 20'h00004,
      S_BOOT   = 20'h00008,
      S_FETCH0 = 20'h00010,
      S_FETCH1 = 20'h00020,
      S_FETCH2 = 20'h00040,
      S_RDX    = 20'h00080,
      S_RDY    = 20'h00100,
      S_EXEC   = 20'h00200,
      S_DMEM   = 20'h00400,
      S_DSCR   = 20'h00800,
      S_DWR    = 20'h01000,
      S_BCD    = 20'h02000,
      S_STO    = 20'h04000,
      S_LDR    = 20'h08000,
      S_LDW    = 20'h10000,
      S_IADV   = 20'h20000,
      S_ROWRD  = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic [3:0] grp;
   logic [7:0] nn;

   assign grp      = sts.opcode[15:12];
   assign nn       = sts.opcode[7:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.cmd      = chip8_pkg::CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            ctl.cmd = chip8_pkg::CMD_CLR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd = chip8_pkg::CMD_CAPTURE;
               case (req_operation)
                  chip8_pkg::OPN_LOAD: state_in = S_LOAD;
                  chip8_pkg::OPN_BOOT: state_in = S_BOOT;
                  chip8_pkg::OPN_EXEC: state_in = S_FETCH0;
                  default:             state_in = S_ROWRD;
               endcase
            end
         end
         S_LOAD: begin
            ctl.cmd  = chip8_pkg::CMD_LOAD;
            state_in = S_ROWRD;
         end
         S_BOOT: begin
            ctl.cmd  = chip8_pkg::CMD_BOOT;
            state_in = S_ROWRD;
         end
         S_FETCH0: begin
            ctl.cmd  = chip8_pkg::CMD_FETCH0;
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            ctl.cmd  = chip8_pkg::CMD_FETCH1;
            state_in = S_FETCH2;
         end
         S_FETCH2: begin
            ctl.cmd  = chip8_pkg::CMD_FETCH2;
            state_in = S_RDX;
         end
         S_RDX: begin
            ctl.cmd  = chip8_pkg::CMD_RDX;
            state_in = S_RDY;
         end
         S_RDY: begin
            ctl.cmd  = chip8_pkg::CMD_RDY;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.cmd  = chip8_pkg::CMD_EXEC;
            state_in = S_ROWRD;
            if (grp == chip8_pkg::GRP_DRAW && sts.opcode[3:0] != 4'd0) begin
               state_in = S_DMEM;
            end else if (grp == chip8_pkg::GRP_MISC) begin
               case (nn)
                  chip8_pkg::NN_BCD:   state_in = S_BCD;
                  chip8_pkg::NN_STORE: state_in = S_STO;
                  chip8_pkg::NN_LOADR: state_in = S_LDR;
                  default:             state_in = S_ROWRD;
               endcase
            end
         end
         S_DMEM: begin
            ctl.cmd  = chip8_pkg::CMD_DMEM;
            state_in = S_DSCR;
         end
         S_DSCR: begin
            // rows below the bottom edge are skipped without a screen write
            ctl.cmd = chip8_pkg::CMD_DSCR;
            if (sts.row_ok)        state_in = S_DWR;
            else if (sts.last_row) state_in = S_ROWRD;
            else                   state_in = S_DMEM;
         end
         S_DWR: begin
            ctl.cmd  = chip8_pkg::CMD_DWR;
            state_in = sts.last_row ? S_ROWRD : S_DMEM;
         end
         S_BCD: begin
            ctl.cmd  = chip8_pkg::CMD_BCD;
            if (sts.last_bcd) state_in = S_ROWRD;
         end
         S_STO: begin
            ctl.cmd  = chip8_pkg::CMD_STO;
            if (sts.last_reg) state_in = S_IADV;
         end
         S_LDR: begin
            ctl.cmd  = chip8_pkg::CMD_LDR;
            state_in = S_LDW;
         end
         S_LDW: begin
            ctl.cmd  = chip8_pkg::CMD_LDW;
            state_in = sts.last_reg ? S_IADV : S_LDR;
         end
         S_IADV: begin
            ctl.cmd  = chip8_pkg::CMD_IADV;
            state_in = S_ROWRD;
         end
         S_ROWRD: begin
            ctl.cmd  = chip8_pkg::CMD_ROWRD;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               ctl.cmd      = chip8_pkg::CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/chip8_dp.sv -----
// Datapath of the CHIP-8 core: architectural registers, memory, screen and ALU.
// Depends on chip8_pkg and chip8_ram.
module chip8_dp (
   input  logic               clock,
   input  logic               reset,
   input  chip8_pkg::req_type req_payload,
   output chip8_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic               csr_wdata,
   input  chip8_pkg::ctl_type ctl,
   output chip8_pkg::sts_type sts
);

   chip8_pkg::req_type req_ff;
   chip8_pkg::rsp_type rsp_ff, rsp_in;

   logic        shift_vx_ff, dbl_adv_ff;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] i_ff, i_in;
   logic [7:0]  v_ff [16];
   logic [11:0] stk_ff [chip8_pkg::STK_DEPTH];
   logic [4:0]  sp_ff, sp_in;
   logic [7:0]  dly_ff, dly_in, snd_ff, snd_in;
   logic        kseen_ff, kseen_in;
   logic [3:0]  kheld_ff, kheld_in;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in, spr_ff, spr_in;
   logic [15:0] op_ff, op_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        wait_ff, wait_in;
   logic [11:0] clr_cnt_ff;
   logic [chip8_pkg::SCR_H-1:0] row_vld_ff, row_vld_in;
   logic        scr_vld_q_ff;

   logic        va_we, vf_we, stk_we, boot;
   logic [3:0]  va_addr;
   logic [7:0]  va_data, vf_data;

   logic        mem_we;
   logic [11:0] mem_addr;
   logic [7:0]  mem_wd, mem_q;
   logic        scr_we;
   logic [4:0]  scr_addr;
   logic [63:0] scr_wd, scr_q, scr_row;

   logic [3:0]  x, y, n, v_rd_addr, sp_dec;
   logic [7:0]  nn, v_rd;
   logic [11:0] nnn, pc2, pc4, i_addr;
   logic [8:0]  yy, sum9, dif_ab, dif_ba;
   logic [63:0] mask;
   logic [11:0] bcd;
   logic [7:0]  shsrc;
   logic [5:0]  adv;
   logic [3:0]  first_key;
   logic        any_key, seen_n, stall;
   logic [3:0]  held_n;

   chip8_ram #(.WIDTH(8), .DEPTH(chip8_pkg::MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wd),
      .rdata (mem_q)
   );

   chip8_ram #(.WIDTH(chip8_pkg::SCR_W), .DEPTH(chip8_pkg::SCR_H)) u_scr (
      .clock (clock),
      .we    (scr_we),
      .addr  (scr_addr),
      .wdata (scr_wd),
      .rdata (scr_q)
   );

   assign x    = op_ff[11:8];
   assign y    = op_ff[7:4];
   assign n    = op_ff[3:0];
   assign nn   = op_ff[7:0];
   assign nnn  = op_ff[11:0];
   assign pc2  = pc_ff + 12'd2;
   assign pc4  = pc_ff + 12'd4;
   assign i_addr = i_ff[11:0] + {8'd0, cnt_ff};
   assign yy   = {1'b0, vy_ff} + {5'd0, cnt_ff};
   assign mask = {spr_ff, 56'd0} >> vx_ff;
   assign scr_row = scr_vld_q_ff ? scr_q : '0;
   assign bcd  = chip8_pkg::BCD_ROM[vx_ff];
   assign shsrc = shift_vx_ff ? vx_ff : vy_ff;
   assign sum9 = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign dif_ab = {1'b0, vx_ff} - {1'b0, vy_ff};
   assign dif_ba = {1'b0, vy_ff} - {1'b0, vx_ff};
   assign adv  = ({2'd0, x} + 6'd1) << dbl_adv_ff;
   assign sp_dec = sp_ff[3:0] - 4'd1;

   always_comb begin
      case (ctl.cmd)
         chip8_pkg::CMD_RDY: v_rd_addr = y;
         chip8_pkg::CMD_STO: v_rd_addr = cnt_ff;
         default:            v_rd_addr = x;
      endcase
   end
   assign v_rd = v_ff[v_rd_addr];

   // lowest pressed key
   always_comb begin
      first_key = 4'd0;
      for (int k = 15; k >= 0; k--) begin
         if (req_ff.keys_down[k]) first_key = 4'(k);
      end
   end
   assign any_key = |req_ff.keys_down;
   assign seen_n  = kseen_ff || any_key;
   assign held_n  = kseen_ff ? kheld_ff : (any_key ? first_key : kheld_ff);
   assign stall   = !seen_n || req_ff.keys_down[held_n];

   always_comb begin
      pc_in = pc_ff;   i_in = i_ff;     sp_in = sp_ff;
      dly_in = dly_ff; snd_in = snd_ff;
      kseen_in = kseen_ff; kheld_in = kheld_ff;
      vx_in = vx_ff;   vy_in = vy_ff;   spr_in = spr_ff;
      op_in = op_ff;   cnt_in = cnt_ff; wait_in = wait_ff;
      row_vld_in = row_vld_ff;
      rsp_in = rsp_ff;
      va_we = 1'b0; va_addr = x; va_data = 8'd0;
      vf_we = 1'b0; vf_data = 8'd0;
      stk_we = 1'b0; boot = 1'b0;
      mem_we = 1'b0; mem_addr = pc_ff; mem_wd = 8'd0;
      scr_we = 1'b0; scr_addr = req_ff.row_select; scr_wd = scr_row ^ mask;

      case (ctl.cmd)
         chip8_pkg::CMD_CLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
            mem_wd   = (clr_cnt_ff < 12'(chip8_pkg::FONT_BYTES))
                       ? chip8_pkg::FONT_ROM[clr_cnt_ff[6:0]] : 8'd0;
         end
         chip8_pkg::CMD_CAPTURE: begin
            op_in   = 16'd0;
            wait_in = 1'b0;
         end
         chip8_pkg::CMD_LOAD: begin
            mem_we   = 1'b1;
            mem_addr = req_ff.load_address;
            mem_wd   = req_ff.load_data;
         end
         chip8_pkg::CMD_BOOT: begin
            boot       = 1'b1;
            pc_in      = chip8_pkg::PC_BOOT;
            i_in       = 16'd0;
            sp_in      = 5'd0;
            dly_in     = 8'd0;
            snd_in     = 8'd0;
            kseen_in   = 1'b0;
            kheld_in   = 4'd0;
            row_vld_in = '0;
         end
         chip8_pkg::CMD_FETCH0: mem_addr = pc_ff;
         chip8_pkg::CMD_FETCH1: begin
            mem_addr = pc_ff + 12'd1;
            op_in    = {mem_q, 8'd0};
         end
         chip8_pkg::CMD_FETCH2: op_in = {op_ff[15:8], mem_q};
         chip8_pkg::CMD_RDX:    vx_in = v_rd;
         chip8_pkg::CMD_RDY:    vy_in = v_rd;
         chip8_pkg::CMD_EXEC: begin
            pc_in  = pc2;
            cnt_in = 4'd0;
            case (op_ff[15:12])
               chip8_pkg::GRP_SYS: begin
                  if (op_ff == chip8_pkg::OP_CLS) begin
                     row_vld_in = '0;
                  end else if (op_ff == chip8_pkg::OP_RET && sp_ff != 5'd0) begin
                     sp_in = sp_ff - 5'd1;
                     pc_in = stk_ff[sp_dec];
                  end
               end
               chip8_pkg::GRP_JP: pc_in = nnn;
               chip8_pkg::GRP_CALL: begin
                  if (!sp_ff[4]) begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + 5'd1;
                     pc_in  = nnn;
                  end
               end
               chip8_pkg::GRP_SE:   pc_in = (vx_ff == nn) ? pc4 : pc2;
               chip8_pkg::GRP_SNE:  pc_in = (vx_ff != nn) ? pc4 : pc2;
               chip8_pkg::GRP_SER:
                  pc_in = (n == 4'd0 && vx_ff == vy_ff) ? pc4 : pc2;
               chip8_pkg::GRP_SNER:
                  pc_in = (n == 4'd0 && vx_ff != vy_ff) ? pc4 : pc2;
               chip8_pkg::GRP_LD: begin
                  va_we = 1'b1; va_data = nn;
               end
               chip8_pkg::GRP_ADD: begin
                  va_we = 1'b1; va_data = vx_ff + nn;
               end
               chip8_pkg::GRP_ALU: begin
                  // flag write lands after Vx, so VF wins when x is 15
                  case (n)
                     chip8_pkg::ALU_MOV: begin
                        va_we = 1'b1; va_data = vy_ff;
                     end
                     chip8_pkg::ALU_OR: begin
                        va_we = 1'b1; va_data = vx_ff | vy_ff; vf_we = 1'b1;
                     end
                     chip8_pkg::ALU_AND: begin
                        va_we = 1'b1; va_data = vx_ff & vy_ff; vf_we = 1'b1;
                     end
                     chip8_pkg::ALU_XOR: begin
                        va_we = 1'b1; va_data = vx_ff ^ vy_ff; vf_we = 1'b1;
                     end
                     chip8_pkg::ALU_ADD: begin
                        va_we = 1'b1; va_data = sum9[7:0];
                        vf_we = 1'b1; vf_data = {7'd0, sum9[8]};
                     end
                     chip8_pkg::ALU_SUB: begin
                        va_we = 1'b1; va_data = dif_ab[7:0];
                        vf_we = 1'b1; vf_data = {7'd0, !dif_ab[8]};
                     end
                     chip8_pkg::ALU_SHR: begin
                        va_we = 1'b1; va_data = {1'b0, shsrc[7:1]};
                        vf_we = 1'b1; vf_data = {7'd0, shsrc[0]};
                     end
                     chip8_pkg::ALU_SUBN: begin
                        va_we = 1'b1; va_data = dif_ba[7:0];
                        vf_we = 1'b1; vf_data = {7'd0, !dif_ba[8]};
                     end
                     chip8_pkg::ALU_SHL: begin
                        va_we = 1'b1; va_data = {shsrc[6:0], 1'b0};
                        vf_we = 1'b1; vf_data = {7'd0, shsrc[7]};
                     end
                     default: va_we = 1'b0;
                  endcase
               end
               chip8_pkg::GRP_LDI:  i_in = {4'd0, nnn};
               chip8_pkg::GRP_JPV0: pc_in = nnn + {4'd0, v_ff[0]};
               chip8_pkg::GRP_RND: begin
                  va_we = 1'b1; va_data = req_ff.random_byte & nn;
               end
               chip8_pkg::GRP_DRAW: vf_we = 1'b1;
               chip8_pkg::GRP_KEY: begin
                  if (nn == chip8_pkg::NN_SKP)
                     pc_in = req_ff.keys_down[vx_ff[3:0]] ? pc4 : pc2;
                  else if (nn == chip8_pkg::NN_SKNP)
                     pc_in = req_ff.keys_down[vx_ff[3:0]] ? pc2 : pc4;
               end
               chip8_pkg::GRP_MISC: begin
                  case (nn)
                     chip8_pkg::NN_GETDLY: begin
                        va_we = 1'b1; va_data = dly_ff;
                     end
                     chip8_pkg::NN_WAITK: begin
                        if (stall) begin
                           pc_in    = pc_ff;
                           wait_in  = 1'b1;
                           kseen_in = seen_n;
                           kheld_in = held_n;
                        end else begin
                           va_we    = 1'b1;
                           va_data  = {4'd0, held_n};
                           kseen_in = 1'b0;
                           kheld_in = 4'd0;
                        end
                     end
                     chip8_pkg::NN_SETDLY: dly_in = vx_ff;
                     chip8_pkg::NN_SETSND: snd_in = vx_ff;
                     chip8_pkg::NN_ADDI:   i_in = i_ff + {8'd0, vx_ff};
                     chip8_pkg::NN_FONT:
                        i_in = {5'd0, {1'b0, vx_ff, 2'b00} + {3'd0, vx_ff}};
                     default: i_in = i_ff;
                  endcase
               end
               default: pc_in = pc2;
            endcase
         end
         chip8_pkg::CMD_DMEM: mem_addr = i_addr;
         chip8_pkg::CMD_DSCR: begin
            spr_in   = mem_q;
            scr_addr = yy[4:0];
            if (!sts.row_ok) cnt_in = cnt_ff + 4'd1;
         end
         chip8_pkg::CMD_DWR: begin
            scr_we   = 1'b1;
            scr_addr = yy[4:0];
            row_vld_in[yy[4:0]] = 1'b1;
            if (|(scr_row & mask)) begin
               vf_we = 1'b1; vf_data = 8'd1;
            end
            cnt_in = cnt_ff + 4'd1;
         end
         chip8_pkg::CMD_BCD: begin
            mem_we   = 1'b1;
            mem_addr = i_addr;
            case (cnt_ff[1:0])
               2'd0:    mem_wd = {4'd0, bcd[11:8]};
               2'd1:    mem_wd = {4'd0, bcd[7:4]};
               default: mem_wd = {4'd0, bcd[3:0]};
            endcase
            cnt_in = cnt_ff + 4'd1;
         end
         chip8_pkg::CMD_STO: begin
            mem_we   = 1'b1;
            mem_addr = i_addr;
            mem_wd   = v_rd;
            cnt_in   = cnt_ff + 4'd1;
         end
         chip8_pkg::CMD_LDR: mem_addr = i_addr;
         chip8_pkg::CMD_LDW: begin
            va_we   = 1'b1;
            va_addr = cnt_ff;
            va_data = mem_q;
            cnt_in  = cnt_ff + 4'd1;
         end
         chip8_pkg::CMD_IADV:  i_in = i_ff + {10'd0, adv};
         chip8_pkg::CMD_ROWRD: scr_addr = req_ff.row_select;
         chip8_pkg::CMD_OUT: begin
            rsp_in.program_counter = pc_ff;
            rsp_in.opcode_done     = op_ff;
            rsp_in.index_value     = i_ff;
            rsp_in.flag_value      = v_ff[15];
            rsp_in.waiting_key     = wait_ff;
            rsp_in.display_row     = scr_row;
            rsp_in.delay_value     = dly_ff;
            rsp_in.sound_value     = snd_ff;
         end
         default: mem_addr = pc_ff;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= chip8_pkg::PC_BOOT;
         i_ff        <= 16'd0;
         sp_ff       <= 5'd0;
         dly_ff      <= 8'd0;
         snd_ff      <= 8'd0;
         kseen_ff    <= 1'b0;
         kheld_ff    <= 4'd0;
         row_vld_ff  <= '0;
         clr_cnt_ff  <= 12'd0;
         shift_vx_ff <= 1'b0;
         dbl_adv_ff  <= 1'b0;
         cnt_ff      <= 4'd0;
         wait_ff     <= 1'b0;
         for (int r = 0; r < 16; r++) v_ff[r] <= 8'd0;
      end else begin
         pc_ff      <= pc_in;
         i_ff       <= i_in;
         sp_ff      <= sp_in;
         dly_ff     <= dly_in;
         snd_ff     <= snd_in;
         kseen_ff   <= kseen_in;
         kheld_ff   <= kheld_in;
         row_vld_ff <= row_vld_in;
         cnt_ff     <= cnt_in;
         wait_ff    <= wait_in;
         if (ctl.cmd == chip8_pkg::CMD_CLR) clr_cnt_ff <= clr_cnt_ff + 12'd1;
         if (csr_we) begin
            if (csr_index == chip8_pkg::CSR_SHIFT_VX) shift_vx_ff <= csr_wdata;
            else                                     dbl_adv_ff  <= csr_wdata;
         end
         if (boot) begin
            for (int r = 0; r < 16; r++) v_ff[r] <= 8'd0;
         end else begin
            // VF takes the flag when both target it
            if (va_we && !(vf_we && va_addr == 4'hF)) v_ff[va_addr] <= va_data;
            if (vf_we) v_ff[15] <= vf_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.cmd == chip8_pkg::CMD_CAPTURE) req_ff <= req_payload;
      op_ff        <= op_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      spr_ff       <= spr_in;
      rsp_ff       <= rsp_in;
      scr_vld_q_ff <= row_vld_ff[scr_addr];
      if (stk_we) stk_ff[sp_ff[3:0]] <= pc2;
   end

   assign sts.clr_last = &clr_cnt_ff;
   assign sts.opcode   = op_ff;
   assign sts.last_row = (cnt_ff == n - 4'd1);
   assign sts.last_reg = (cnt_ff == x);
   assign sts.last_bcd = (cnt_ff == 4'd2);
   assign sts.row_ok   = (yy < 9'(chip8_pkg::SCR_H));
   assign rsp_payload  = rsp_ff;

endmodule

// ----- hw/rtl/chip8_instruction_core.sv -----
// CHIP-8 core: one request per transfer, one response per request.
// One item in flight; rate set by the single-port program memory sequencer.
// After reset a memory pass over all 4096 bytes loads the font and zeroes the rest; requests wait.
// Depends on chip8_pkg, chip8_ctrl, chip8_dp.
module chip8_instruction_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  chip8_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output chip8_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic               csr_wdata
);

   chip8_pkg::ctl_type ctl;
   chip8_pkg::sts_type sts;

   chip8_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .ctl           (ctl)
   );

   chip8_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ctl         (ctl),
      .sts         (sts)
   );

endmodule

// ----- hw/rtl/chip8_checker.sv -----
// Port-level checks for chip8_instruction_core, bound to the top level.
// Depends on chip8_pkg.
module chip8_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input chip8_pkg::rsp_type rsp_payload
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one item in flight: a transfer closes the request side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a response is only issued from the busy side of the sequencer
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while idle");

   // key wait is only reported for Fx0A
   a_wait_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.waiting_key |->
         rsp_payload.opcode_done[15:12] == chip8_pkg::GRP_MISC &&
         rsp_payload.opcode_done[7:0] == chip8_pkg::NN_WAITK)
      else $error("key wait on wrong opcode");

endmodule

bind chip8_instruction_core chip8_checker u_chk (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for chip8_instruction_core: directed and random item
// streams, checked against an in-bench CHIP-8 predictor. Depends on chip8_pkg.
`timescale 1ns / 1ps

class chip8_scoreboard;
   chip8_pkg::rsp_type expected_rsps[$];
   int                 failures;
   int                 checked;

   // note an accepted request's prediction
   function void note_request(chip8_pkg::rsp_type r);
      expected_rsps.push_back(r);
   endfunction

   function void check_response(chip8_pkg::rsp_type got);
      chip8_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         $display("%0t: response with nothing expected: %h", $time, got);
         failures++;
         return;
      end
      want = expected_rsps.pop_front();
      checked++;
      if (got.program_counter != want.program_counter) begin
         $display("%0t: pc exp %h got %h", $time, want.program_counter,
                  got.program_counter);
         failures++;
      end
      if (got.opcode_done != want.opcode_done) begin
         $display("%0t: opcode exp %h got %h", $time, want.opcode_done, got.opcode_done);
         failures++;
      end
      if (got.index_value != want.index_value) begin
         $display("%0t: I exp %h got %h", $time, want.index_value, got.index_value);
         failures++;
      end
      if (got.flag_value != want.flag_value) begin
         $display("%0t: VF exp %h got %h", $time, want.flag_value, got.flag_value);
         failures++;
      end
      if (got.waiting_key != want.waiting_key) begin
         $display("%0t: waiting exp %b got %b", $time, want.waiting_key, got.waiting_key);
         failures++;
      end
      if (got.display_row != want.display_row) begin
         $display("%0t: row exp %h got %h", $time, want.display_row, got.display_row);
         failures++;
      end
      if (got.delay_value != want.delay_value) begin
         $display("%0t: delay exp %h got %h", $time, want.delay_value, got.delay_value);
         failures++;
      end
      if (got.sound_value != want.sound_value) begin
         $display("%0t: sound exp %h got %h", $time, want.sound_value, got.sound_value);
         failures++;
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 2000000;
   // random steps; each averages about 2.4 transfers
   localparam int RANDOM_ITEMS = 480;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   chip8_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_ready;
   chip8_pkg::rsp_type rsp_payload;
   logic               csr_we;
   logic               csr_index;
   logic               csr_wdata;

   chip8_instruction_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   chip8_scoreboard sb = new();

   // predictor state
   logic [7:0]  mem_img [chip8_pkg::MEM_BYTES];
   logic [63:0] scr_img [chip8_pkg::SCR_H];
   logic [7:0]  vreg [16];
   logic [15:0] ireg;
   logic [11:0] pc_reg;
   logic [11:0] stk [chip8_pkg::STK_DEPTH];
   int          stk_lvl;
   logic [7:0]  dly_reg, snd_reg;
   logic        key_latched;
   logic [3:0]  key_num;
   logic        cfg_shift_vx, cfg_dbl_adv;

   int  cycles;
   int  sent;
   bit  hold_rsp;     // long receiver hold-off request

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic int short_or_long_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void cpu_boot();
      pc_reg = chip8_pkg::PC_BOOT;
      stk_lvl = 0;
      ireg = '0;
      dly_reg = '0;
      snd_reg = '0;
      key_latched = 1'b0;
      key_num = '0;
      for (int i = 0; i < 16; i++) vreg[i] = '0;
      for (int i = 0; i < chip8_pkg::STK_DEPTH; i++) stk[i] = '0;
      for (int i = 0; i < chip8_pkg::SCR_H; i++) scr_img[i] = '0;
   endfunction

   function automatic void skip_when(bit c);
      if (c) pc_reg = pc_reg + 12'd2;
   endfunction

   function automatic void alu_op(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      logic [8:0] a, b, src, r;
      logic       f;
      a = {1'b0, vreg[x]};
      b = {1'b0, vreg[y]};
      src = cfg_shift_vx ? a : b;
      case (n)
         chip8_pkg::ALU_MOV:  begin vreg[x] = b[7:0]; return; end
         chip8_pkg::ALU_OR:   begin r = a | b; f = 1'b0; end
         chip8_pkg::ALU_AND:  begin r = a & b; f = 1'b0; end
         chip8_pkg::ALU_XOR:  begin r = a ^ b; f = 1'b0; end
         chip8_pkg::ALU_ADD:  begin r = a + b; f = r[8]; end
         chip8_pkg::ALU_SUB:  begin r = a - b; f = a >= b; end
         chip8_pkg::ALU_SHR:  begin r = src >> 1; f = src[0]; end
         chip8_pkg::ALU_SUBN: begin r = b - a; f = b >= a; end
         chip8_pkg::ALU_SHL:  begin r = src << 1; f = src[7]; end
         default: return;
      endcase
      vreg[x] = r[7:0];
      vreg[15] = {7'b0, f};
   endfunction

   function automatic void sprite_draw(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      int px, py, yy, xx;
      logic [7:0] bits;
      px = vreg[x];
      py = vreg[y];
      vreg[15] = '0;
      for (int row = 0; row < n; row++) begin
         bits = mem_img[12'(ireg + row)];
         yy = py + row;
         if (yy >= chip8_pkg::SCR_H) continue;
         for (int col = 0; col < 8; col++) begin
            xx = px + col;
            if (xx >= chip8_pkg::SCR_W || !bits[7 - col]) continue;
            if (scr_img[yy][63 - xx]) vreg[15] = 8'd1;
            scr_img[yy][63 - xx] = ~scr_img[yy][63 - xx];
         end
      end
   endfunction

   // one instruction; returns 1 while a key wait is still pending
   function automatic bit run_instruction(logic [15:0] keys, logic [7:0] rnd,
                                          output logic [15:0] word);
      logic [3:0]  x, y, n;
      logic [7:0]  nn;
      logic [11:0] nnn;
      logic [15:0] adv;
      word = {mem_img[pc_reg], mem_img[12'(pc_reg + 1)]};
      nnn = word[11:0];
      nn = word[7:0];
      n = word[3:0];
      x = word[11:8];
      y = word[7:4];
      pc_reg = pc_reg + 12'd2;
      case (word[15:12])
         chip8_pkg::GRP_SYS: begin
            if (word == chip8_pkg::OP_CLS) begin
               for (int i = 0; i < chip8_pkg::SCR_H; i++) scr_img[i] = '0;
            end else if (word == chip8_pkg::OP_RET && stk_lvl > 0) begin
               stk_lvl--;
               pc_reg = stk[stk_lvl];
            end
         end
         chip8_pkg::GRP_JP: pc_reg = nnn;
         chip8_pkg::GRP_CALL: begin
            if (stk_lvl < chip8_pkg::STK_DEPTH) begin
               stk[stk_lvl] = pc_reg;
               stk_lvl++;
               pc_reg = nnn;
            end
         end
         chip8_pkg::GRP_SE:   skip_when(vreg[x] == nn);
         chip8_pkg::GRP_SNE:  skip_when(vreg[x] != nn);
         chip8_pkg::GRP_SER:  skip_when(n == 0 && vreg[x] == vreg[y]);
         chip8_pkg::GRP_LD:   vreg[x] = nn;
         chip8_pkg::GRP_ADD:  vreg[x] = vreg[x] + nn;
         chip8_pkg::GRP_ALU:  alu_op(x, y, n);
         chip8_pkg::GRP_SNER: skip_when(n == 0 && vreg[x] != vreg[y]);
         chip8_pkg::GRP_LDI:  ireg = {4'b0, nnn};
         chip8_pkg::GRP_JPV0: pc_reg = nnn + {4'b0, vreg[0]};
         chip8_pkg::GRP_RND:  vreg[x] = rnd & nn;
         chip8_pkg::GRP_DRAW: sprite_draw(x, y, n);
         chip8_pkg::GRP_KEY: begin
            if (nn == chip8_pkg::NN_SKP) skip_when(keys[vreg[x][3:0]]);
            else if (nn == chip8_pkg::NN_SKNP) skip_when(!keys[vreg[x][3:0]]);
         end
         chip8_pkg::GRP_MISC: begin
            adv = (16'(x) + 16'd1) * (cfg_dbl_adv ? 16'd2 : 16'd1);
            case (nn)
               chip8_pkg::NN_GETDLY: vreg[x] = dly_reg;
               chip8_pkg::NN_WAITK: begin
                  if (!key_latched) begin
                     for (int i = 0; i < 16; i++) begin
                        if (keys[i]) begin
                           key_latched = 1'b1;
                           key_num = 4'(i);
                           break;
                        end
                     end
                  end
                  if (!key_latched || keys[key_num]) begin
                     pc_reg = pc_reg - 12'd2;
                     return 1'b1;
                  end
                  vreg[x] = {4'b0, key_num};
                  key_latched = 1'b0;
                  key_num = '0;
               end
               chip8_pkg::NN_SETDLY: dly_reg = vreg[x];
               chip8_pkg::NN_SETSND: snd_reg = vreg[x];
               chip8_pkg::NN_ADDI:   ireg = ireg + {8'b0, vreg[x]};
               chip8_pkg::NN_FONT:   ireg = 16'(vreg[x]) * 16'd5;
               chip8_pkg::NN_BCD: begin
                  mem_img[ireg[11:0]] = vreg[x] / 100;
                  mem_img[12'(ireg + 1)] = (vreg[x] / 10) % 10;
                  mem_img[12'(ireg + 2)] = vreg[x] % 10;
               end
               chip8_pkg::NN_STORE: begin
                  for (int i = 0; i <= x; i++) mem_img[12'(ireg + i)] = vreg[i];
                  ireg = ireg + adv;
               end
               chip8_pkg::NN_LOADR: begin
                  for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(ireg + i)];
                  ireg = ireg + adv;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic chip8_pkg::rsp_type predict_step(chip8_pkg::req_type q);
      chip8_pkg::rsp_type r;
      logic [15:0]        word;
      bit                 waiting;
      word = '0;
      waiting = 0;
      case (q.operation)
         chip8_pkg::OPN_LOAD: mem_img[q.load_address] = q.load_data;
         chip8_pkg::OPN_BOOT: cpu_boot();
         chip8_pkg::OPN_EXEC: waiting = run_instruction(q.keys_down, q.random_byte, word);
         default: ;
      endcase
      r.program_counter = pc_reg;
      r.opcode_done = word;
      r.index_value = ireg;
      r.flag_value = vreg[15];
      r.waiting_key = waiting;
      r.display_row = scr_img[q.row_select];
      r.delay_value = dly_reg;
      r.sound_value = snd_reg;
      return r;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(chip8_pkg::req_type q);
      idle_cycles(short_or_long_gap());
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(predict_step(q));
      sent++;
      req_valid <= 1'b0;
      // the block is busy after a transfer anyway
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      idle_cycles(40);
   endtask

   task automatic write_csr(logic idx, logic val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == chip8_pkg::CSR_SHIFT_VX) cfg_shift_vx = val;
      else cfg_dbl_adv = val;
   endtask

   function automatic chip8_pkg::req_type make_req(logic [1:0] opn);
      chip8_pkg::req_type q;
      q.operation = opn;
      q.load_address = 12'($urandom);
      q.load_data = 8'($urandom);
      q.keys_down = 16'($urandom);
      q.random_byte = 8'($urandom);
      q.row_select = 5'($urandom);
      return q;
   endfunction

   task automatic load_byte(logic [11:0] a, logic [7:0] d);
      chip8_pkg::req_type q;
      q = make_req(chip8_pkg::OPN_LOAD);
      q.load_address = a;
      q.load_data = d;
      send_item(q);
   endtask

   task automatic exec_word(logic [15:0] w, logic [15:0] keys);
      chip8_pkg::req_type q;
      load_byte(pc_reg, w[15:8]);
      load_byte(12'(pc_reg + 1), w[7:0]);
      q = make_req(chip8_pkg::OPN_EXEC);
      q.keys_down = keys;
      send_item(q);
   endtask

   // random instruction, biased to useful forms
   function automatic logic [15:0] random_word();
      logic [15:0] w;
      int k;
      w = 16'($urandom);
      k = $urandom_range(0, 19);
      case (k)
         0: w = $urandom_range(0, 1) ? chip8_pkg::OP_CLS : chip8_pkg::OP_RET;
         1: w[15:12] = chip8_pkg::GRP_ALU;
         2: begin
            w[15:12] = chip8_pkg::GRP_ALU;
            w[3:0] = $urandom_range(0, 1) ? chip8_pkg::ALU_SHR : chip8_pkg::ALU_SHL;
         end
         3: begin
            w[15:12] = chip8_pkg::GRP_KEY;
            w[7:0] = $urandom_range(0, 1) ? chip8_pkg::NN_SKP : chip8_pkg::NN_SKNP;
         end
         4, 5: begin
            w[15:12] = chip8_pkg::GRP_MISC;
            case ($urandom_range(0, 9))
               0: w[7:0] = chip8_pkg::NN_GETDLY;
               1: w[7:0] = chip8_pkg::NN_SETDLY;
               2: w[7:0] = chip8_pkg::NN_SETSND;
               3: w[7:0] = chip8_pkg::NN_ADDI;
               4: w[7:0] = chip8_pkg::NN_FONT;
               5: w[7:0] = chip8_pkg::NN_BCD;
               6: w[7:0] = chip8_pkg::NN_STORE;
               7: w[7:0] = chip8_pkg::NN_LOADR;
               8: w[7:0] = chip8_pkg::NN_WAITK;
               default: ;
            endcase
         end
         6, 7: w[15:12] = chip8_pkg::GRP_DRAW;
         8: w[15:12] = chip8_pkg::GRP_LD;
         9: w[15:12] = chip8_pkg::GRP_LDI;
         10: w[15:12] = chip8_pkg::GRP_CALL;
         default: ;
      endcase
      return w;
   endfunction

   task automatic random_phase(int count);
      chip8_pkg::req_type q;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 70) begin
            exec_word(random_word(), ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom));
         end else if (k < 80) begin
            q = make_req(chip8_pkg::OPN_EXEC);
            if ($urandom_range(0, 1)) q.keys_down = 16'h0;
            send_item(q);
         end else if (k < 92) send_item(make_req(chip8_pkg::OPN_READ));
         else if (k < 97) send_item(make_req(chip8_pkg::OPN_LOAD));
         else send_item(make_req(chip8_pkg::OPN_BOOT));
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         n = short_or_long_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         sb.check_response(rsp_payload);
         rsp_ready <= 1'b0;
      end
   end

   initial begin
      cycles = 0;
      sent = 0;
      hold_rsp = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = 1'b0;
      cfg_shift_vx = 0;
      cfg_dbl_adv = 0;
      for (int i = 0; i < chip8_pkg::MEM_BYTES; i++)
         mem_img[i] = (i < chip8_pkg::FONT_BYTES) ? chip8_pkg::FONT_ROM[i] : 8'h0;
      cpu_boot();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: register setup, ALU flags, shifts both ways, draws, stack, key wait
      exec_word(16'h60FF, 16'h0);
      exec_word(16'h6101, 16'h0);
      exec_word(16'h8014, 16'h0);   // carry
      exec_word(16'h8015, 16'h0);
      exec_word(16'h8017, 16'h0);
      exec_word(16'h801E, 16'h0);
      exec_word(16'h8016, 16'h0);
      exec_word(16'hA000, 16'h0);
      exec_word(16'h623C, 16'h0);   // x near right edge
      exec_word(16'h631E, 16'h0);   // y near bottom
      exec_word(16'hD235, 16'h0);
      exec_word(16'hD235, 16'h0);   // collision
      exec_word(16'h00EE, 16'h0);   // empty-stack return
      exec_word(16'hCAFF, 16'h0);
      exec_word(16'hF10A, 16'h0);   // no key
      exec_word(16'hF10A, 16'h8001);
      exec_word(16'hF10A, 16'h0);   // released
      exec_word(16'hFF33, 16'h0);
      exec_word(16'hFF55, 16'h0);
      exec_word(16'h1FFE, 16'hFFFF); // address wrap
      exec_word(16'hF065, 16'hFFFF);
      send_item(make_req(chip8_pkg::OPN_BOOT));

      write_csr(chip8_pkg::CSR_SHIFT_VX, 1'b1);
      write_csr(chip8_pkg::CSR_DBL_ADV, 1'b1);
      random_phase(RANDOM_ITEMS / 4);

      // receiver holds off while the sender keeps offering
      hold_rsp = 1;
      random_phase(RANDOM_ITEMS / 4);
      write_csr(chip8_pkg::CSR_SHIFT_VX, 1'b0);
      random_phase(RANDOM_ITEMS / 4);
      write_csr(chip8_pkg::CSR_DBL_ADV, 1'b0);
      write_csr(chip8_pkg::CSR_SHIFT_VX, 1'b1);
      random_phase(RANDOM_ITEMS / 4);

      wait_drained();
      $display("%0d requests sent, %0d responses checked; both quirk settings exercised",
               sent, sb.checked);
      if (sb.failures == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule
